@@ hdl/ipe_pkg.sv @@
package ipe_pkg;

  localparam int DEF_MAX_WIDTH       = 256;
  localparam int DEF_MAX_HEIGHT      = 256;
  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int COLOR_W    = 16;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PALETTE = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOUR_BIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 9'd192;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BOX   = 1'b1;

  localparam logic [7:0]         MAGENTA_MIN = 8'd248;
  localparam logic [7:0]         GREEN_MAX   = 8'd8;
  localparam logic [COLOR_W-1:0] OPAQUE_BIT  = 16'h8000;

  typedef struct packed {
    logic is_box;  // finish request, report box
    logic two;     // second nibble falls inside the row
    logic hit0;    // first index maps to a written palette entry
    logic hit1;    // second index maps to a written palette entry
  } ipe_ctl_t;

  function automatic logic [COLOR_W-1:0] pal_color(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
    logic [COLOR_W-1:0] c;
    if (r >= MAGENTA_MIN && g <= GREEN_MAX && b >= MAGENTA_MIN) begin
      c = '0;
    end else begin
      c = OPAQUE_BIT | {1'b0, b[7:3], g[7:3], r[7:3]};
    end
    return c;
  endfunction

endpackage

@@ hdl/ipe_if.sv @@
interface ipe_in_if;
  import ipe_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [7:0]      palette_index;
  logic [7:0]      red;
  logic [7:0]      green;
  logic [7:0]      blue;
  logic [7:0]      data_byte;

  modport source (output valid, op, palette_index, red, green, blue, data_byte,
                  input ready);
  modport sink (input valid, op, palette_index, red, green, blue, data_byte,
                output ready);
endinterface

interface ipe_out_if;
  import ipe_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         pixel_x;
  logic [7:0]         pixel_y;
  logic [COLOR_W-1:0] color;
  logic [7:0]         box_x;
  logic [7:0]         box_y;
  logic [8:0]         box_width;
  logic [8:0]         box_height;
  logic               last;

  modport source (output valid, kind, pixel_x, pixel_y, color, box_x, box_y,
                  box_width, box_height, last, input ready);
  modport sink (input valid, kind, pixel_x, pixel_y, color, box_x, box_y,
                box_width, box_height, last, output ready);
endinterface

interface ipe_cfg_if;
  import ipe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/ipe_ram.sv @@
module ipe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hdl/ipe_front.sv @@
module ipe_front #(
  parameter int MAX_WIDTH       = ipe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = ipe_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = ipe_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  ipe_cfg_if.sink                            cfg,
  ipe_in_if.sink                             pix_in,
  input  logic                               take_ok,
  output logic                               pal_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_waddr,
  output logic [ipe_pkg::COLOR_W-1:0]        pal_wdata,
  output logic                               pal_re,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_raddr_a,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] pal_raddr_b,
  output logic                               load,
  output ipe_pkg::ipe_ctl_t                  ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]       x0,
  output logic [$clog2(MAX_WIDTH)-1:0]       x1,
  output logic [$clog2(MAX_HEIGHT)-1:0]      y,
  output logic [$clog2(MAX_WIDTH+1)-1:0]     eff_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]    eff_h
);
  import ipe_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int BW = $clog2(MAX_WIDTH + 4);
  localparam int PW = BW + 1;
  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic                   four_bit_mode;
  logic [CFG_DATA_W-1:0]  image_width;
  logic [CFG_DATA_W-1:0]  image_height;
  logic [BW-1:0]          byte_in_row;
  logic [HW-1:0]          rows_done;
  logic [PALETTE_ENTRIES-1:0] pal_valid;

  logic          accept;
  logic          is_data;
  logic          is_finish;
  logic          rows_left;
  logic          row_end;
  logic [BW-1:0] w_ext;
  logic [BW-1:0] row_bytes;
  logic [PW-1:0] px0;
  logic [PW-1:0] px1;
  logic          exists0;
  logic          exists1;
  logic [7:0]    idx_a;
  logic [7:0]    idx_b;
  logic          in_range_a;

  assign cfg.ready    = 1'b1;
  assign pix_in.ready = take_ok;
  assign accept       = pix_in.valid && take_ok;
  assign is_data      = pix_in.op == OP_DATA;
  assign is_finish    = pix_in.op == OP_FINISH;

  // clamp the programmed size into the supported range
  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
  end

  // bytes per padded row
  assign w_ext     = BW'(eff_w);
  assign row_bytes = four_bit_mode ?
                     ((((w_ext + BW'(1)) >> 1) + BW'(3)) & ~BW'(3)) :
                     ((w_ext + BW'(3)) & ~BW'(3));
  assign row_end   = (PW'(byte_in_row) + PW'(1)) >= PW'(row_bytes);
  assign rows_left = rows_done < eff_h;

  assign px0     = four_bit_mode ? {byte_in_row, 1'b0} : PW'(byte_in_row);
  assign px1     = px0 + PW'(1);
  assign exists0 = px0 < PW'(eff_w);
  assign exists1 = four_bit_mode && (px1 < PW'(eff_w));

  assign x0 = XW'(px0);
  assign x1 = XW'(px1);
  assign y  = YW'(eff_h - HW'(1) - rows_done);

  // high nibble first in 4-bit mode
  assign idx_a      = four_bit_mode ? {4'b0, pix_in.data_byte[7:4]} : pix_in.data_byte;
  assign idx_b      = {4'b0, pix_in.data_byte[3:0]};
  assign in_range_a = 32'(idx_a) < 32'(PALETTE_ENTRIES);

  assign pal_we      = accept && (pix_in.op == OP_PALETTE) &&
                       (32'(pix_in.palette_index) < 32'(PALETTE_ENTRIES));
  assign pal_waddr   = AW'(pix_in.palette_index);
  assign pal_wdata   = pal_color(pix_in.red, pix_in.green, pix_in.blue);
  assign pal_raddr_a = AW'(idx_a);
  assign pal_raddr_b = AW'(idx_b);

  assign load   = accept && ((is_data && rows_left && exists0) || is_finish);
  assign pal_re = load;

  assign ctl.is_box = is_finish;
  assign ctl.two    = exists1;
  assign ctl.hit0   = in_range_a && pal_valid[pal_raddr_a];
  assign ctl.hit1   = pal_valid[pal_raddr_b];

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b1;
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      byte_in_row   <= '0;
      rows_done     <= '0;
      pal_valid     <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_FOUR_BIT_MODE: four_bit_mode <= cfg.data[0];
          REG_IMAGE_WIDTH:   image_width   <= cfg.data;
          REG_IMAGE_HEIGHT:  image_height  <= cfg.data;
          default: ;
        endcase
      end
      if (pal_we) begin
        pal_valid[pal_waddr] <= 1'b1;
      end
      if (accept) begin
        unique case (pix_in.op)
          OP_DATA: begin
            // drop bytes once every row is done
            if (rows_left) begin
              if (row_end) begin
                byte_in_row <= '0;
                rows_done   <= rows_done + HW'(1);
              end else begin
                byte_in_row <= byte_in_row + BW'(1);
              end
            end
          end
          OP_FINISH: begin
            byte_in_row <= '0;
            rows_done   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ hdl/ipe_emit.sv @@
module ipe_emit #(
  parameter int MAX_WIDTH  = ipe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ipe_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  ipe_pkg::ipe_ctl_t               ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]    x0,
  input  logic [$clog2(MAX_WIDTH)-1:0]    x1,
  input  logic [$clog2(MAX_HEIGHT)-1:0]   y,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] eff_h,
  input  logic [ipe_pkg::COLOR_W-1:0]     rdata_a,
  input  logic [ipe_pkg::COLOR_W-1:0]     rdata_b,
  output logic                            take_ok,
  ipe_out_if.source                       pix_out
);
  import ipe_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  // clamped size after reset, the starting left and top edges
  localparam int RST_W = (int'(RST_IMAGE_WIDTH) > MAX_WIDTH) ? MAX_WIDTH :
                         int'(RST_IMAGE_WIDTH);
  localparam int RST_H = (int'(RST_IMAGE_HEIGHT) > MAX_HEIGHT) ? MAX_HEIGHT :
                         int'(RST_IMAGE_HEIGHT);

  logic          s1_valid;
  ipe_ctl_t      s1_ctl;
  logic [XW-1:0] s1_x0;
  logic [XW-1:0] s1_x1;
  logic [YW-1:0] s1_y;
  logic          sel;

  logic          any_opq;
  logic [WW-1:0] left;
  logic [XW-1:0] right;
  logic [HW-1:0] top;
  logic [YW-1:0] bottom;

  logic               move;
  logic               last_now;
  logic               retire;
  logic [COLOR_W-1:0] color0;
  logic [COLOR_W-1:0] color1;
  logic               opq0;
  logic               opq1;
  logic [XW-1:0]      lo;
  logic [XW-1:0]      hi;
  logic [7:0]         bx;
  logic [7:0]         by;
  logic [8:0]         bw;
  logic [8:0]         bh;

  // unwritten entries read as transparent
  assign color0 = s1_ctl.hit0 ? rdata_a : '0;
  assign color1 = s1_ctl.hit1 ? rdata_b : '0;
  assign opq0   = color0 != '0;
  assign opq1   = s1_ctl.two && (color1 != '0);
  assign lo     = opq0 ? s1_x0 : s1_x1;
  assign hi     = opq1 ? s1_x1 : s1_x0;

  assign move     = s1_valid && (!pix_out.valid || pix_out.ready);
  assign last_now = s1_ctl.is_box || !s1_ctl.two || sel;
  assign retire   = move && last_now;
  assign take_ok  = !s1_valid || retire;

  always_comb begin
    if (any_opq) begin
      bx = 8'(left);
      by = 8'(top);
      bw = 9'(WW'(right) - left + WW'(1));
      bh = 9'(HW'(bottom) - top + HW'(1));
    end else begin
      bx = '0;
      by = '0;
      bw = 9'(eff_w);
      bh = 9'(eff_h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      any_opq       <= 1'b0;
      left          <= WW'(RST_W);
      top           <= HW'(RST_H);
      pix_out.valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        pix_out.valid <= 1'b1;
      end else if (pix_out.ready) begin
        pix_out.valid <= 1'b0;
      end
      // left and top start from the size in force when the box is cleared
      if (retire && s1_ctl.is_box) begin
        any_opq <= 1'b0;
        left    <= eff_w;
        top     <= eff_h;
      end else if (retire && (opq0 || opq1)) begin
        any_opq <= 1'b1;
        left    <= (WW'(lo) < left) ? WW'(lo) : left;
        top     <= (HW'(s1_y) < top) ? HW'(s1_y) : top;
      end
    end

    if (load) begin
      s1_ctl <= ctl;
      s1_x0  <= x0;
      s1_x1  <= x1;
      s1_y   <= y;
      sel    <= 1'b0;
    end else if (move && !last_now) begin
      sel <= 1'b1;
    end

    // grow the box once the request retires
    if (retire && !s1_ctl.is_box && (opq0 || opq1)) begin
      right  <= (!any_opq || hi > right) ? hi : right;
      bottom <= (!any_opq || s1_y > bottom) ? s1_y : bottom;
    end

    if (move) begin
      if (s1_ctl.is_box) begin
        pix_out.kind       <= KIND_BOX;
        pix_out.pixel_x    <= '0;
        pix_out.pixel_y    <= '0;
        pix_out.color      <= '0;
        pix_out.box_x      <= bx;
        pix_out.box_y      <= by;
        pix_out.box_width  <= bw;
        pix_out.box_height <= bh;
        pix_out.last       <= 1'b1;
      end else begin
        pix_out.kind       <= KIND_PIXEL;
        pix_out.pixel_x    <= 8'(sel ? s1_x1 : s1_x0);
        pix_out.pixel_y    <= 8'(s1_y);
        pix_out.color      <= sel ? color1 : color0;
        pix_out.box_x      <= '0;
        pix_out.box_y      <= '0;
        pix_out.box_width  <= '0;
        pix_out.box_height <= '0;
        pix_out.last       <= last_now;
      end
    end
  end

endmodule

@@ hdl/indexed_pixel_expand_with_bbox.sv @@
// Indexed pixel expander with opaque bounding box.
// pix_in carries requests: palette writes (op 0), raw row bytes (op 1, bottom
// row first, rows padded to 4 bytes) and finish (op 2). pix_out carries
// pixel results (x, y, 15-bit color with bit 15 set, or 0 when transparent)
// and the box result of a finish; last marks the final result of a request.
// cfg writes four_bit_mode, image_width and image_height; write it only when
// the block is idle.
// The accepting edge registers the palette read, and the output register
// then loads the result once pix_out is free to take it.
// Throughput: one request per cycle while pix_out does not stall and each
// gives at most one result; a byte that yields two pixels holds the result
// stage until both have moved, since pix_out moves one result per cycle.
// Palette writes take effect for the very next request.
// Reset: the palette reads as all transparent, the row position and the box
// are cleared, registers return to 4-bit mode, 256 x 192.
// When the receiver stalls, the output register holds its result and the
// result stage fills; pix_in.ready then drops until pix_out drains.
module indexed_pixel_expand_with_bbox #(
  parameter int MAX_WIDTH       = ipe_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = ipe_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = ipe_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic      clk,
  input  logic      rst,
  ipe_cfg_if.sink   cfg,
  ipe_in_if.sink    pix_in,
  ipe_out_if.source pix_out
);
  import ipe_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic               pal_we;
  logic [AW-1:0]      pal_waddr;
  logic [COLOR_W-1:0] pal_wdata;
  logic               pal_re;
  logic [AW-1:0]      pal_raddr_a;
  logic [AW-1:0]      pal_raddr_b;
  logic [COLOR_W-1:0] pal_rdata_a;
  logic [COLOR_W-1:0] pal_rdata_b;
  logic               load;
  ipe_ctl_t           ctl;
  logic [XW-1:0]      x0;
  logic [XW-1:0]      x1;
  logic [YW-1:0]      y;
  logic [WW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic               take_ok;

  ipe_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix_in     (pix_in),
    .take_ok    (take_ok),
    .pal_we     (pal_we),
    .pal_waddr  (pal_waddr),
    .pal_wdata  (pal_wdata),
    .pal_re     (pal_re),
    .pal_raddr_a(pal_raddr_a),
    .pal_raddr_b(pal_raddr_b),
    .load       (load),
    .ctl        (ctl),
    .x0         (x0),
    .x1         (x1),
    .y          (y),
    .eff_w      (eff_w),
    .eff_h      (eff_h)
  );

  ipe_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .we     (pal_we),
    .waddr  (pal_waddr),
    .wdata  (pal_wdata),
    .re     (pal_re),
    .raddr_a(pal_raddr_a),
    .raddr_b(pal_raddr_b),
    .rdata_a(pal_rdata_a),
    .rdata_b(pal_rdata_b)
  );

  ipe_emit #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .ctl    (ctl),
    .x0     (x0),
    .x1     (x1),
    .y      (y),
    .eff_w  (eff_w),
    .eff_h  (eff_h),
    .rdata_a(pal_rdata_a),
    .rdata_b(pal_rdata_b),
    .take_ok(take_ok),
    .pix_out(pix_out)
  );

endmodule

@@ hdl/ipe_checker.sv @@
module ipe_protocol_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [7:0]                  out_pixel_x,
  input logic [ipe_pkg::COLOR_W-1:0] out_color,
  input logic [7:0]                  out_box_x,
  input logic [7:0]                  out_box_y,
  input logic [8:0]                  out_box_width,
  input logic [8:0]                  out_box_height,
  input logic                        out_last
);
  import ipe_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_box_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_BOX |->
      out_last && out_box_width != '0 && out_box_height != '0)
    else $error("box result not last or empty");

  a_pixel_no_box: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_PIXEL |->
      out_box_x == '0 && out_box_y == '0 &&
      out_box_width == '0 && out_box_height == '0)
    else $error("pixel result carries box fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pixel_x) && $stable(out_color) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind indexed_pixel_expand_with_bbox ipe_protocol_check u_ipe_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (pix_out.valid),
  .out_ready     (pix_out.ready),
  .out_kind      (pix_out.kind),
  .out_pixel_x   (pix_out.pixel_x),
  .out_color     (pix_out.color),
  .out_box_x     (pix_out.box_x),
  .out_box_y     (pix_out.box_y),
  .out_box_width (pix_out.box_width),
  .out_box_height(pix_out.box_height),
  .out_last      (pix_out.last)
);
